// ----- hw/rtl/pso_pkg.sv -----
// Shared types, fixed-point constants and series coefficients for the
// pixel strip overlap area pipeline. No dependencies.
package pso_pkg;

	localparam int QB                      = 30;
	localparam int SERIES_TERMS            = 7;
	localparam int INTERCEPT_FRAC_BITS_DEF = 16;

	localparam logic [30:0]        Q_ONE_U  = 31'h4000_0000;
	localparam logic signed [63:0] Q_ONE_L  = 64'sd1073741824;
	localparam logic signed [63:0] Q_HALF_L = 64'sd536870912;

	typedef enum logic [2:0] {
		PC_FULL,
		PC_TRAP_TRI,
		PC_TRAP,
		PC_TRI,
		PC_ZERO
	} pair_case_t;

	typedef struct packed {
		pair_case_t  code;
		logic [63:0] d;
	} pair_sel_t;

	typedef struct packed {
		logic signed [31:0] icpt;
		logic               neg;
		logic [30:0]        x;
	} item_t;

	// Horner divisors for term k: cos uses (2k-1)(2k), sin uses (2k)(2k+1)
	function automatic int unsigned cos_div(input int unsigned k);
		return (2 * k - 1) * (2 * k);
	endfunction

	function automatic int unsigned sin_div(input int unsigned k);
		return (2 * k) * (2 * k + 1);
	endfunction

endpackage

// ----- hw/rtl/pixel_strip_overlap_area.sv -----
// Pixel strip overlap area: covered part of a unit pixel for one ray strip.
// Depends on pso_pkg and pso_div_pipe.
//
//  channel   signals                              dir   handshake
//  request   start, strip_intercept, view_angle   in    start & !busy
//  result    done, covered_area                   out   done, one cycle
//
// One request enters every cycle; busy stays low. The chain runs through the
// series, the tan/sec division and the corner area division, plus 10 stages.
// Reset clears only the valid bits that travel with each request.
// The receiver cannot stall, so the pipeline never holds.
module pixel_strip_overlap_area #(
	parameter int INTERCEPT_FRAC_BITS = pso_pkg::INTERCEPT_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] strip_intercept,
	input  logic signed [14:0] view_angle,
	output logic               done,
	output logic [16:0]        covered_area
);

	localparam int C_SHIFT = pso_pkg::QB - INTERCEPT_FRAC_BITS;
	localparam int NT      = pso_pkg::SERIES_TERMS;
	localparam int CODE_W  = $bits(pso_pkg::pair_case_t);

	function automatic pso_pkg::pair_sel_t classify(input logic signed [63:0] l1,
			input logic signed [63:0] l2);
		pso_pkg::pair_sel_t r;
		logic ge1a, ge0a, ge1b, ge0b;
		ge1a   = l1 >= pso_pkg::Q_ONE_L;
		ge0a   = !l1[63];
		ge1b   = l2 >= pso_pkg::Q_ONE_L;
		ge0b   = !l2[63];
		r.d    = '0;
		r.code = pso_pkg::PC_ZERO;
		if (ge1a) begin
			if (ge1b) begin
				r.code = pso_pkg::PC_FULL;
			end else begin
				r.code = pso_pkg::PC_TRAP_TRI;
				r.d    = l1 - pso_pkg::Q_ONE_L;
			end
		end else if (ge0a) begin
			if (ge1b) begin
				r.code = pso_pkg::PC_TRAP_TRI;
				r.d    = l2 - pso_pkg::Q_ONE_L;
			end else if (ge0b) begin
				r.code = pso_pkg::PC_TRAP;
			end else begin
				r.code = pso_pkg::PC_TRI;
				r.d    = l1;
			end
		end else if (ge0b) begin
			r.code = pso_pkg::PC_TRI;
			r.d    = l2;
		end
		return r;
	endfunction

	// signed halving that truncates toward zero
	function automatic logic signed [63:0] half_of(input logic signed [63:0] l1,
			input logic signed [63:0] l2);
		logic signed [63:0] s;
		s = l1 + l2;
		return (s + $signed({63'd0, s[63]})) >>> 1;
	endfunction

	function automatic logic signed [63:0] pair_value(input pso_pkg::pair_case_t code,
			input logic signed [63:0] half, input logic [63:0] q);
		logic signed [63:0] v;
		case (code)
			pso_pkg::PC_FULL:     v = pso_pkg::Q_ONE_L;
			pso_pkg::PC_TRAP_TRI: v = half - $signed(q);
			pso_pkg::PC_TRAP:     v = half;
			pso_pkg::PC_TRI:      v = $signed(q);
			default:              v = '0;
		endcase
		return v;
	endfunction

	assign busy = 1'b0;

	// ---- stage 1: fold sign off the angle
	logic               vld_s1;
	logic signed [31:0] icpt_s1;
	logic               neg_s1;
	logic [14:0]        mag_s1;
	logic [15:0]        mag_neg;

	assign mag_neg = 16'h8000 - {1'b0, view_angle};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		icpt_s1 <= strip_intercept;
		neg_s1  <= view_angle[14];
		mag_s1  <= view_angle[14] ? mag_neg[14:0] : view_angle;
	end

	// ---- stage 2: x and x squared, seeds series index 0
	logic [30:0] x_w;
	logic [61:0] x2_prod;

	assign x_w     = {mag_s1, 16'd0};
	assign x2_prod = x_w * x_w;

	logic                  ser_vld [NT+1];
	pso_pkg::item_t        ser_it  [NT+1];
	logic [30:0]           ser_x2  [NT+1];
	logic [30:0]           ser_rc  [NT+1];
	logic [30:0]           ser_rs  [NT+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_vld[0] <= 1'b0;
		end else begin
			ser_vld[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ser_it[0] <= '{icpt: icpt_s1, neg: neg_s1, x: x_w};
		ser_x2[0] <= x2_prod[60:30];
		ser_rc[0] <= pso_pkg::Q_ONE_U;
		ser_rs[0] <= pso_pkg::Q_ONE_U;
	end

	// ---- series: three stages per Horner term, cos and sin side by side
	for (genvar j = 0; j < NT; j++) begin : g_term
		localparam int unsigned K    = NT - j;
		localparam int unsigned DC_I = pso_pkg::cos_div(K);
		localparam int unsigned DS_I = pso_pkg::sin_div(K);
		localparam logic [7:0]  DC   = 8'(DC_I);
		localparam logic [7:0]  DS   = 8'(DS_I);
		localparam logic [31:0] MC   = 32'((64'd1 << 32) / DC_I);
		localparam logic [31:0] MS   = 32'((64'd1 << 32) / DS_I);

		logic           v_s1, v_s2;
		pso_pkg::item_t it_s1, it_s2;
		logic [30:0]    x2_s1, x2_s2;
		logic [30:0]    yc_s1, ys_s1, yc_s2, ys_s2;
		logic [30:0]    qc_s2, qs_s2;
		logic [61:0]    pc, ps;
		logic [62:0]    mc, ms;
		logic [30:0]    rc_rem, rs_rem, qc, qs;

		always_comb begin
			pc     = ser_x2[j] * ser_rc[j];
			ps     = ser_x2[j] * ser_rs[j];
			mc     = yc_s1 * MC;
			ms     = ys_s1 * MS;
			rc_rem = yc_s2 - 31'(qc_s2 * DC);
			rs_rem = ys_s2 - 31'(qs_s2 * DS);
			qc     = qc_s2 + {30'd0, rc_rem >= {23'd0, DC}};
			qs     = qs_s2 + {30'd0, rs_rem >= {23'd0, DS}};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1         <= 1'b0;
				v_s2         <= 1'b0;
				ser_vld[j+1] <= 1'b0;
			end else begin
				v_s1         <= ser_vld[j];
				v_s2         <= v_s1;
				ser_vld[j+1] <= v_s2;
			end
		end

		always_ff @(posedge clk) begin
			it_s1       <= ser_it[j];
			x2_s1       <= ser_x2[j];
			yc_s1       <= pc[60:30];
			ys_s1       <= ps[60:30];
			it_s2       <= it_s1;
			x2_s2       <= x2_s1;
			yc_s2       <= yc_s1;
			ys_s2       <= ys_s1;
			qc_s2       <= mc[62:32];
			qs_s2       <= ms[62:32];
			ser_it[j+1] <= it_s2;
			ser_x2[j+1] <= x2_s2;
			ser_rc[j+1] <= pso_pkg::Q_ONE_U - qc;
			ser_rs[j+1] <= pso_pkg::Q_ONE_U - qs;
		end
	end

	// ---- stage 3: sin = x * rs
	logic               vld_s3;
	logic signed [31:0] icpt_s3;
	logic               neg_s3;
	logic [30:0]        cos_s3, sin_s3;
	logic [61:0]        sin_prod;

	assign sin_prod = ser_it[NT].x * ser_rs[NT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= ser_vld[NT];
		end
	end

	always_ff @(posedge clk) begin
		icpt_s3 <= ser_it[NT].icpt;
		neg_s3  <= ser_it[NT].neg;
		cos_s3  <= ser_rc[NT];
		sin_s3  <= sin_prod[60:30];
	end

	// ---- tan and sec dividers, rounded by adding cos/2
	logic [30:0] cos_nz;
	logic [61:0] tan_num;
	logic [61:0] sec_num;

	assign cos_nz  = (cos_s3 == '0) ? 31'd1 : cos_s3;
	assign tan_num = {1'b0, sin_s3, 30'd0} + {32'd0, cos_nz[30:1]};
	assign sec_num = {1'b0, 1'b1, 60'd0} + {32'd0, cos_nz[30:1]};

	logic               tan_vld, sec_vld;
	logic [30:0]        tan_q, sec_q;
	logic signed [31:0] icpt_d;
	logic               neg_d;

	pso_div_pipe #(.DEN_W(31), .QUO_W(31), .SIDE_W(32)) u_div_tan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.rem_in   (tan_num[61:31]),
		.lo_in    (tan_num[30:0]),
		.den      (cos_nz),
		.side_in  (icpt_s3),
		.out_vld  (tan_vld),
		.quo      (tan_q),
		.side_out (icpt_d)
	);

	pso_div_pipe #(.DEN_W(31), .QUO_W(31), .SIDE_W(1)) u_div_sec (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.rem_in   (sec_num[61:31]),
		.lo_in    (sec_num[30:0]),
		.den      (cos_nz),
		.side_in  (neg_s3),
		.out_vld  (sec_vld),
		.quo      (sec_q),
		.side_out (neg_d)
	);

	// ---- stage 4: partial sums of the edge offsets
	logic signed [63:0] c_w, ht_w, hs_w;
	logic               vld_s4;
	logic signed [63:0] base_s4, p_s4, m_s4;
	logic [31:0]        den_s4;

	assign c_w  = 64'(icpt_d) <<< C_SHIFT;
	assign hs_w = {34'd0, sec_q[30:1]};
	assign ht_w = neg_d ? -$signed({34'd0, tan_q[30:1]}) : $signed({34'd0, tan_q[30:1]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= tan_vld & sec_vld;
		end
	end

	always_ff @(posedge clk) begin
		base_s4 <= pso_pkg::Q_HALF_L - hs_w;
		p_s4    <= ht_w - c_w;
		m_s4    <= ht_w + c_w;
		den_s4  <= {tan_q[30:1], 2'b00};
	end

	// ---- stage 5: edge offsets la1, la2, lb1 and lb2
	logic               vld_s5;
	logic signed [63:0] la1_s5, la2_s5, lb1_s5, lb2_s5;
	logic [31:0]        den_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		la1_s5 <= base_s4 + p_s4;
		la2_s5 <= base_s4 - m_s4;
		lb1_s5 <= base_s4 - p_s4;
		lb2_s5 <= base_s4 + m_s4;
		den_s5 <= den_s4;
	end

	// ---- stage 6: pick the corner rule of each pair
	logic               vld_s6;
	pso_pkg::pair_sel_t sel_a_s6, sel_b_s6;
	logic signed [63:0] half_a_s6, half_b_s6;
	logic [31:0]        den_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		sel_a_s6  <= classify(la1_s5, la2_s5);
		sel_b_s6  <= classify(lb1_s5, lb2_s5);
		half_a_s6 <= half_of(la1_s5, la2_s5);
		half_b_s6 <= half_of(lb1_s5, lb2_s5);
		den_s6    <= den_s5;
	end

	// ---- stage 7: partial products of d squared, modulo 2^64
	logic                vld_s7;
	pso_pkg::pair_case_t code_a_s7, code_b_s7;
	logic signed [63:0]  half_a_s7, half_b_s7;
	logic [63:0]         pa0_s7, pb0_s7;
	logic [30:0]         pa1_s7, pb1_s7;
	logic [31:0]         den_s7;
	logic [63:0]         pa1_w, pb1_w;

	assign pa1_w = sel_a_s6.d[63:32] * sel_a_s6.d[31:0];
	assign pb1_w = sel_b_s6.d[63:32] * sel_b_s6.d[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		code_a_s7 <= sel_a_s6.code;
		code_b_s7 <= sel_b_s6.code;
		half_a_s7 <= half_a_s6;
		half_b_s7 <= half_b_s6;
		pa0_s7    <= sel_a_s6.d[31:0] * sel_a_s6.d[31:0];
		pb0_s7    <= sel_b_s6.d[31:0] * sel_b_s6.d[31:0];
		pa1_s7    <= pa1_w[30:0];
		pb1_s7    <= pb1_w[30:0];
		den_s7    <= den_s6;
	end

	// ---- stage 8: combine into d squared
	logic                vld_s8;
	pso_pkg::pair_case_t code_a_s8, code_b_s8;
	logic signed [63:0]  half_a_s8, half_b_s8;
	logic [63:0]         nn_a_s8, nn_b_s8;
	logic [31:0]         den_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		code_a_s8 <= code_a_s7;
		code_b_s8 <= code_b_s7;
		half_a_s8 <= half_a_s7;
		half_b_s8 <= half_b_s7;
		nn_a_s8   <= pa0_s7 + {pa1_s7, 33'd0};
		nn_b_s8   <= pb0_s7 + {pb1_s7, 33'd0};
		den_s8    <= den_s7;
	end

	// ---- corner triangle quotients
	logic                    qa_vld, qb_vld;
	logic [63:0]             qa, qb;
	logic [CODE_W+63:0]      side_a, side_b;
	pso_pkg::pair_case_t     code_a_d, code_b_d;
	logic signed [63:0]      half_a_d, half_b_d;

	pso_div_pipe #(.DEN_W(32), .QUO_W(64), .SIDE_W(CODE_W + 64)) u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s8),
		.rem_in   (32'd0),
		.lo_in    (nn_a_s8),
		.den      (den_s8),
		.side_in  ({code_a_s8, half_a_s8}),
		.out_vld  (qa_vld),
		.quo      (qa),
		.side_out (side_a)
	);

	pso_div_pipe #(.DEN_W(32), .QUO_W(64), .SIDE_W(CODE_W + 64)) u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s8),
		.rem_in   (32'd0),
		.lo_in    (nn_b_s8),
		.den      (den_s8),
		.side_in  ({code_b_s8, half_b_s8}),
		.out_vld  (qb_vld),
		.quo      (qb),
		.side_out (side_b)
	);

	assign code_a_d = pso_pkg::pair_case_t'(side_a[CODE_W+63:64]);
	assign code_b_d = pso_pkg::pair_case_t'(side_b[CODE_W+63:64]);
	assign half_a_d = side_a[63:0];
	assign half_b_d = side_b[63:0];

	// ---- stage 9: sum of both corner areas
	logic               vld_s9;
	logic signed [63:0] sum_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else begin
			vld_s9 <= qa_vld & qb_vld;
		end
	end

	always_ff @(posedge clk) begin
		sum_s9 <= pair_value(code_a_d, half_a_d, qa) + pair_value(code_b_d, half_b_d, qb);
	end

	// ---- stage 10: saturate and round to Q1.16
	logic signed [63:0] area_w;
	logic [30:0]        area_sat;
	logic [30:0]        area_rnd;

	always_comb begin
		area_w = pso_pkg::Q_ONE_L - sum_s9;
		if (area_w[63]) begin
			area_sat = '0;
		end else if (area_w > pso_pkg::Q_ONE_L) begin
			area_sat = pso_pkg::Q_ONE_U;
		end else begin
			area_sat = area_w[30:0];
		end
		area_rnd = area_sat + 31'h2000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		covered_area <= area_rnd[30:14];
	end

endmodule

// ----- hw/rtl/pso_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Stand-alone; used by pixel_strip_overlap_area for tan, sec and corner areas.
module pso_div_pipe #(
	parameter int DEN_W  = 32,
	parameter int QUO_W  = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [DEN_W-1:0]  rem_in,   // upper numerator bits, must be below den
	input  logic [QUO_W-1:0]  lo_in,    // lower numerator bits
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [QUO_W-1:0]  quo,
	output logic [SIDE_W-1:0] side_out
);

	logic              vld_s  [QUO_W+1];
	logic [DEN_W-1:0]  rem_s  [QUO_W+1];
	logic [QUO_W-1:0]  lo_s   [QUO_W+1];
	logic [DEN_W-1:0]  den_s  [QUO_W+1];
	logic [SIDE_W-1:0] side_s [QUO_W+1];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = rem_in;
	assign lo_s[0]   = lo_in;
	assign den_s[0]  = den;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		logic [DEN_W:0] t;
		logic [DEN_W:0] diff;
		logic           ge;

		always_comb begin
			t    = {rem_s[i], lo_s[i][QUO_W-1]};
			diff = t - {1'b0, den_s[i]};
			ge   = t >= {1'b0, den_s[i]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1]  <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
			lo_s[i+1]   <= {lo_s[i][QUO_W-2:0], ge};
			den_s[i+1]  <= den_s[i];
			side_s[i+1] <= side_s[i];
		end
	end

	assign out_vld  = vld_s[QUO_W];
	assign quo      = lo_s[QUO_W];
	assign side_out = side_s[QUO_W];

endmodule

// ----- tb/testbench.sv -----
// Testbench for pixel_strip_overlap_area: drives strip requests, predicts
// the covered pixel area in fixed point and checks each done strobe.
// Depends on the RTL top level pixel_strip_overlap_area only.
`timescale 1ns / 100ps

class area_scoreboard;
	logic [16:0] pending_area[$];
	int unsigned mismatches;
	int unsigned checked;

	function automatic longint corner_area(longint l1, longint l2);
		longint one;
		longint unsigned d, den;
		one = 64'sd1 << 30;
		if (l1 >= one) begin
			if (l2 >= one)
				return one;
			d = l1 - one;
			den = 2 * (l1 - l2);
			return (l1 + l2) / 2 - longint'((d * d) / den);
		end
		if (l1 >= 0) begin
			if (l2 >= one) begin
				d = l2 - one;
				den = 2 * (l2 - l1);
				return (l1 + l2) / 2 - longint'((d * d) / den);
			end
			if (l2 >= 0)
				return (l1 + l2) / 2;
			d = l1;
			den = 2 * (l1 - l2);
			return longint'((d * d) / den);
		end
		if (l2 >= 0) begin
			d = l2;
			den = 2 * (l2 - l1);
			return longint'((d * d) / den);
		end
		return 0;
	endfunction

	function automatic logic [16:0] covered(logic signed [31:0] icpt,
			logic signed [14:0] ang);
		longint unsigned one, mag, x, x2, rc, rs, cosv, sinv, tanm, secv, kk;
		longint c, ht, hs, area, half;
		bit neg;
		one = 64'd1 << 30;
		half = 64'sd1 << 29;
		neg = ang[14];
		mag = neg ? (64'd32768 - {49'd0, ang}) : {49'd0, ang};
		x = mag << 16;
		x2 = (x * x) >> 30;
		rc = one;
		rs = one;
		for (int k = 7; k >= 1; k--) begin
			kk = k;
			rc = one - ((x2 * rc) >> 30) / ((2 * kk - 1) * (2 * kk));
			rs = one - ((x2 * rs) >> 30) / ((2 * kk) * (2 * kk + 1));
		end
		cosv = rc;
		sinv = (x * rs) >> 30;
		if (cosv == 0)
			cosv = 1;
		tanm = ((sinv << 30) + cosv / 2) / cosv;
		secv = ((64'd1 << 60) + cosv / 2) / cosv;
		ht = longint'(tanm >> 1);
		if (neg)
			ht = -ht;
		hs = longint'(secv >> 1);
		c = longint'(icpt) * (64'sd1 << 14);
		area = longint'(one) - (corner_area(half + ht - c - hs, half - ht - c - hs)
			+ corner_area(half - ht + c - hs, half + ht + c - hs));
		if (area < 0)
			area = 0;
		if (area > longint'(one))
			area = one;
		return 17'((longint'(area) + (64'sd1 << 13)) >>> 14);
	endfunction

	function void note_request(logic signed [31:0] icpt, logic signed [14:0] ang);
		pending_area = {pending_area, covered(icpt, ang)};
	endfunction

	function void check_result(logic [16:0] got);
		logic [16:0] want;
		if (pending_area.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result covered_area=%0d", got);
			return;
		end
		want = pending_area.pop_front();
		checked++;
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch covered_area expected %0d actual %0d", want, got);
		end
	endfunction
endclass

module testbench;
	localparam int IDLE_LIMIT = 2000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [31:0] strip_intercept = '0;
	logic signed [14:0] view_angle = '0;
	logic               done;
	logic [16:0]        covered_area;

	area_scoreboard areas = new();
	int unsigned idle_cycles;
	int unsigned sent;

	pixel_strip_overlap_area i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.strip_intercept(strip_intercept),
		.view_angle(view_angle),
		.done(done),
		.covered_area(covered_area)
	);

	always #6 clk = ~clk;

	// Requests and results are sampled at the edge; drives land after it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				areas.note_request(strip_intercept, view_angle);
				sent++;
			end
			if (done)
				areas.check_result(covered_area);
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog expired");
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Hold start until the request is taken; drop it only if a gap follows.
	task automatic send_request(logic signed [31:0] icpt, logic signed [14:0] ang,
			int unsigned gap);
		start <= 1'b1;
		strip_intercept <= icpt;
		view_angle <= ang;
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			strip_intercept <= $urandom;
			view_angle <= 15'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic int unsigned draw_gap(bit bursty);
		return bursty ? 0 : $urandom_range(0, 16);
	endfunction

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (areas.pending_area.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic signed [14:0] ang;
		logic signed [31:0] icpt;
		int unsigned mode;
		bit bursty;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of both fields, angle past pi/4, far intercepts both sides
		send_request(32'sd0, 15'sd0, 0);
		send_request(32'sh7fffffff, 15'sd0, 1);
		send_request(32'sh80000000, 15'sd0, 0);
		send_request(32'sd0, 15'sh3fff, 2);
		send_request(32'sd0, 15'sh4000, 0);
		send_request(32'sd0, 15'sd12868, 0);
		send_request(32'sd0, -15'sd12868, 3);
		send_request(32'sd32768, 15'sd0, 0);
		send_request(-32'sd32768, 15'sd0, 0);
		send_request(32'sd65536, 15'sd6000, 0);
		send_request(-32'sd65536, -15'sd6000, 0);
		send_request(32'sd98304, 15'sd12868, 0);
		send_request(32'sd20000, 15'sh3fff, 0);
		send_request(-32'sd20000, 15'sh4000, 0);
		send_request(32'sd131072, 15'sd0, 0);
		send_request(32'sd50000, -15'sd9000, 0);
		send_request(-32'sd1, 15'sd1, 0);
		send_request(32'sd1, -15'sd1, 4);

		// hold off until the pipeline has emptied
		drain();

		bursty = 0;
		for (int n = 0; n < 700; n++) begin
			if (n % 50 == 0)
				bursty = ($urandom_range(0, 2) == 0);
			mode = $urandom_range(0, 9);
			ang = (mode < 7) ? 15'($signed($urandom_range(0, 25736)) - 12868)
				: 15'($urandom);
			if (mode < 6)
				icpt = $signed($urandom_range(0, 196608)) - 32'sd98304;
			else if (mode < 8)
				icpt = $signed($urandom_range(0, 4194304)) - 32'sd2097152;
			else
				icpt = $urandom;
			send_request(icpt, ang, draw_gap(bursty));
			if (n == 350)
				drain();
		end

		drain();
		repeat (200) @(posedge clk);
		$display("Covered %0d strip requests: field extremes, angles to +/-1 rad,",
			sent);
		$display("near and far intercepts, with random and back-to-back spacing.");
		if (areas.mismatches == 0 && areas.pending_area.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
